>>> rtl/core/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator.
// Needs clk and rst_n in scope where a macro is used.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [20:0] req_size;
    logic [19:0] addr;
  } in_item_t;

  typedef struct packed {
    logic [19:0] result_addr;
    logic [1:0]  status;
    logic [20:0] copy_bytes;
    logic [47:0] bytes_allocated_total;
    logic [47:0] bytes_freed_total;
    logic [31:0] alloc_count;
    logic [31:0] free_count;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_INIT,
    CMD_LOAD,
    CMD_HEAD,
    CMD_HEAD_MOVE,
    CMD_AWALK,
    CMD_GRANT,
    CMD_SPLIT,
    CMD_FWALK,
    CMD_FREE,
    CMD_RD_CUR,
    CMD_RD_NX,
    CMD_MEVAL,
    CMD_MOVE_RD,
    CMD_MOVE_WR,
    CMD_SWEEP
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       addr_zero;
    logic       req_zero;
    logic       fit;
    logic       split;
    logic       match;
    logic       keep;
    logic       move;
    logic       q_end;
    logic       pair;
    logic       nx_is_last;
    logic       sweep_end;
  } dp_stat_t;

endpackage

>>> rtl/core/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
//   channel   handshake        payload
//   input     start / busy     in_data  (op, req_size, addr)
//   result    out_valid        out_data (address, status, copy size, statistics)
//
// One transaction at a time. Steps per operation:
//   allocate: walk to the first free block that fits, grant it, split it if room.
//   free: walk to find the block, release it, then run the merge pass; each merge moves
//   the last table entry into the released slot, unless that slot is the last one.
//   resize that moves: both walks, the grant and any split, then the merge pass.
// Reset is synchronous; after reset the controller writes the initial block, busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES      = 1048576,
  parameter int HEADER_BYTES    = 24,
  parameter int MAX_BLOCKS      = 256,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ffha_pkg::out_item_t out_data
);
  import ffha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  ffha_dp #(
    .HEAP_BYTES      (HEAP_BYTES),
    .HEADER_BYTES    (HEADER_BYTES),
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/ffha_ctrl.sv
// Controller state machine of the first-fit heap allocator.
// Depends on ffha_pkg and first_fit_heap_allocator_assert.svh.
`include "first_fit_heap_allocator_assert.svh"
module ffha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output ffha_pkg::dp_cmd_t cmd,
  input  ffha_pkg::dp_stat_t stat
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_AWALK, S_GRANT, S_SPLIT, S_FWALK, S_MVHEAD,
    S_FREE, S_RDCUR, S_RDNX, S_MEVAL, S_MVRD, S_MVWR, S_SWEEP
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = CMD_NOP;
    case (state_r)
      S_INIT: begin
        cmd       = CMD_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.op == OP_ALLOC || (stat.op == OP_RESIZE && stat.addr_zero)) begin
          cmd       = CMD_HEAD;
          state_nxt = S_AWALK;
        end else if ((stat.op inside {OP_FREE, OP_RESIZE}) && !stat.addr_zero) begin
          cmd       = CMD_HEAD;
          state_nxt = S_FWALK;
        end else begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_AWALK: begin
        cmd = CMD_AWALK;
        if (stat.fit) begin
          state_nxt = S_GRANT;
        end else if (stat.q_end) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_GRANT: begin
        cmd = CMD_GRANT;
        if (stat.split) begin
          state_nxt = S_SPLIT;
        end else if (stat.move) begin
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd = CMD_SPLIT;
        if (stat.move) begin
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_FWALK: begin
        cmd = CMD_FWALK;
        if (stat.match) begin
          if (stat.op == OP_FREE || stat.req_zero) begin
            state_nxt = S_FREE;
          end else if (stat.keep) begin
            state_nxt = S_IDLE;
            valid_nxt = 1'b1;
          end else begin
            state_nxt = S_MVHEAD;
          end
        end else if (stat.q_end) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_MVHEAD: begin
        cmd       = CMD_HEAD_MOVE;
        state_nxt = S_AWALK;
      end
      S_FREE: begin
        cmd       = CMD_FREE;
        state_nxt = S_RDCUR;
      end
      S_RDCUR: begin
        cmd       = CMD_RD_CUR;
        state_nxt = S_RDNX;
      end
      S_RDNX: begin
        cmd = CMD_RD_NX;
        if (stat.q_end) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end else begin
          state_nxt = S_MEVAL;
        end
      end
      S_MEVAL: begin
        cmd = CMD_MEVAL;
        if (stat.pair) begin
          state_nxt = stat.nx_is_last ? S_RDCUR : S_MVRD;
        end else if (stat.q_end) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
        end
      end
      S_MVRD: begin
        cmd       = CMD_MOVE_RD;
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        cmd       = CMD_MOVE_WR;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        cmd = CMD_SWEEP;
        if (stat.sweep_end) begin
          state_nxt = S_RDCUR;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

  `FFHA_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held for two cycles")
  `FFHA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `FFHA_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while busy")

endmodule

>>> rtl/core/ffha_dp.sv
// Datapath of the first-fit heap allocator: block table memory, walk
// registers and statistics. Depends on ffha_pkg and the assertion header.
`include "first_fit_heap_allocator_assert.svh"
module ffha_dp #(
  parameter int HEAP_BYTES      = 1048576,
  parameter int HEADER_BYTES    = 24,
  parameter int MAX_BLOCKS      = 256,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::in_item_t  in_data,
  input  ffha_pkg::dp_cmd_t   cmd,
  output ffha_pkg::dp_stat_t  stat,
  output ffha_pkg::out_item_t out_data
);
  import ffha_pkg::*;

  localparam int SW = $clog2(HEAP_BYTES + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = ((SW > 21) ? SW : 21) + 2;

  typedef struct packed {
    logic [SW-1:0] off;
    logic [SW-1:0] size;
    logic          free;
    logic [IW-1:0] link;
  } blk_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  blk_t mem [MAX_BLOCKS];
  blk_t q_r;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  blk_t          mem_wd;

  logic [1:0]    op_r, op_nxt;
  logic [20:0]   req_r, req_nxt;
  logic [19:0]   addr_r, addr_nxt;
  logic [19:0]   res_r, res_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [20:0]   copy_r, copy_nxt;
  logic          move_r, move_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] nx_r, nx_nxt;
  logic [IW-1:0] p_r, p_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  blk_t          ient_r, ient_nxt;
  blk_t          hold_r, hold_nxt;
  logic [SW-1:0] old_size_r, old_size_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [47:0]   sum_a_r, sum_a_nxt;
  logic [47:0]   sum_f_r, sum_f_nxt;
  logic [31:0]   n_a_r, n_a_nxt;
  logic [31:0]   n_f_r, n_f_nxt;

  logic [CW-1:0] last;
  logic [IW-1:0] last_i;
  logic [EW-1:0] size_e, req_e, hdr_e, off_e;
  logic          fit, split, match, keep, q_end;

  assign last   = used_r - CW'(1);
  assign last_i = last[IW-1:0];
  assign size_e = EW'(q_r.size);
  assign req_e  = EW'(req_r);
  assign hdr_e  = EW'(HEADER_BYTES);
  assign off_e  = EW'(q_r.off);
  assign keep   = size_e >= req_e;
  assign fit    = q_r.free && keep;
  assign split  = (size_e >= req_e + hdr_e + EW'(MIN_SPLIT_BYTES)) &&
                  (used_r < CW'(MAX_BLOCKS));
  assign match  = !q_r.free && (off_e + hdr_e == EW'(addr_r));
  assign q_end  = (q_r.link == '0) || (CW'(q_r.link) >= used_r);

  always_comb begin
    stat.op         = op_r;
    stat.addr_zero  = (addr_r == '0);
    stat.req_zero   = (req_r == '0);
    stat.fit        = fit;
    stat.split      = split;
    stat.match      = match;
    stat.keep       = keep;
    stat.move       = move_r;
    stat.q_end      = q_end;
    stat.pair       = hold_r.free && q_r.free;
    stat.nx_is_last = (nx_r == last_i);
    stat.sweep_end  = (p_r == last_i - IW'(1));
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = cur_r;
    mem_wd       = q_r;
    mem_re       = 1'b0;
    mem_ra       = cur_r;
    op_nxt       = op_r;
    req_nxt      = req_r;
    addr_nxt     = addr_r;
    res_nxt      = res_r;
    status_nxt   = status_r;
    copy_nxt     = copy_r;
    move_nxt     = move_r;
    cur_nxt      = cur_r;
    nx_nxt       = nx_r;
    p_nxt        = p_r;
    idx_nxt      = idx_r;
    ient_nxt     = ient_r;
    hold_nxt     = hold_r;
    old_size_nxt = old_size_r;
    used_nxt     = used_r;
    sum_a_nxt    = sum_a_r;
    sum_f_nxt    = sum_f_r;
    n_a_nxt      = n_a_r;
    n_f_nxt      = n_f_r;
    case (cmd)
      CMD_INIT: begin
        mem_we      = 1'b1;
        mem_wa      = '0;
        mem_wd.off  = '0;
        mem_wd.size = SW'(HEAP_BYTES - HEADER_BYTES);
        mem_wd.free = 1'b1;
        mem_wd.link = '0;
        used_nxt    = CW'(1);
      end
      CMD_LOAD: begin
        op_nxt     = in_data.op;
        req_nxt    = in_data.req_size;
        addr_nxt   = in_data.addr;
        res_nxt    = '0;
        status_nxt = ST_OK;
        copy_nxt   = '0;
        move_nxt   = 1'b0;
      end
      CMD_HEAD: begin
        mem_re  = 1'b1;
        mem_ra  = '0;
        cur_nxt = '0;
      end
      CMD_HEAD_MOVE: begin
        mem_re   = 1'b1;
        mem_ra   = '0;
        cur_nxt  = '0;
        move_nxt = 1'b1;
      end
      CMD_AWALK: begin
        if (!fit) begin
          if (q_end) begin
            status_nxt = ST_NO_FIT;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = q_r.link;
            cur_nxt = q_r.link;
          end
        end
      end
      CMD_GRANT: begin
        mem_we      = 1'b1;
        mem_wa      = cur_r;
        mem_wd.free = 1'b0;
        if (split) begin
          mem_wd.size = SW'(req_r);
          mem_wd.link = used_r[IW-1:0];
          used_nxt    = used_r + CW'(1);
          sum_a_nxt   = sat_add48(sum_a_r, 48'(req_r));
        end else begin
          sum_a_nxt   = sat_add48(sum_a_r, 48'(q_r.size));
        end
        n_a_nxt  = sat_inc32(n_a_r);
        res_nxt  = 20'(off_e + hdr_e);
        copy_nxt = move_r ? 21'(old_size_r) : '0;
      end
      CMD_SPLIT: begin
        mem_we      = 1'b1;
        mem_wa      = last_i;
        mem_wd.off  = SW'(off_e + hdr_e + req_e);
        mem_wd.size = SW'(size_e - req_e - hdr_e);
        mem_wd.free = 1'b1;
        mem_wd.link = q_r.link;
      end
      CMD_FWALK: begin
        if (match) begin
          idx_nxt      = cur_r;
          ient_nxt     = q_r;
          old_size_nxt = q_r.size;
          if (op_r == OP_RESIZE && req_r != '0 && keep) begin
            res_nxt = addr_r;
          end
        end else if (q_end) begin
          status_nxt = ST_BAD_ADDR;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = q_r.link;
          cur_nxt = q_r.link;
        end
      end
      CMD_FREE: begin
        mem_we      = 1'b1;
        mem_wa      = idx_r;
        mem_wd      = ient_r;
        mem_wd.free = 1'b1;
        sum_f_nxt   = sat_add48(sum_f_r, 48'(ient_r.size));
        n_f_nxt     = sat_inc32(n_f_r);
        cur_nxt     = '0;
      end
      CMD_RD_CUR: begin
        mem_re = 1'b1;
        mem_ra = cur_r;
      end
      CMD_RD_NX: begin
        hold_nxt = q_r;
        nx_nxt   = q_r.link;
        if (!q_end) begin
          mem_re = 1'b1;
          mem_ra = q_r.link;
        end
      end
      CMD_MEVAL: begin
        if (hold_r.free && q_r.free) begin
          mem_we      = 1'b1;
          mem_wa      = cur_r;
          mem_wd.off  = hold_r.off;
          mem_wd.size = SW'(EW'(hold_r.size) + hdr_e + size_e);
          mem_wd.free = hold_r.free;
          mem_wd.link = q_r.link;
          if (nx_r == last_i) begin
            used_nxt = last;
          end
        end else begin
          hold_nxt = q_r;
          cur_nxt  = nx_r;
          nx_nxt   = q_r.link;
          if (!q_end) begin
            mem_re = 1'b1;
            mem_ra = q_r.link;
          end
        end
      end
      CMD_MOVE_RD: begin
        mem_re = 1'b1;
        mem_ra = last_i;
      end
      CMD_MOVE_WR: begin
        mem_we = 1'b1;
        mem_wa = nx_r;
        mem_wd = q_r;
        mem_re = 1'b1;
        mem_ra = '0;
        p_nxt  = '0;
      end
      CMD_SWEEP: begin
        if (q_r.link == last_i) begin
          mem_we      = 1'b1;
          mem_wa      = p_r;
          mem_wd.link = nx_r;
        end
        if (p_r == last_i - IW'(1)) begin
          used_nxt = last;
          if (cur_r == last_i) begin
            cur_nxt = nx_r;
          end
        end else begin
          p_nxt  = p_r + IW'(1);
          mem_re = 1'b1;
          mem_ra = p_r + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= CW'(1);
      sum_a_r <= '0;
      sum_f_r <= '0;
      n_a_r   <= '0;
      n_f_r   <= '0;
      move_r  <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      sum_a_r <= sum_a_nxt;
      sum_f_r <= sum_f_nxt;
      n_a_r   <= n_a_nxt;
      n_f_r   <= n_f_nxt;
      move_r  <= move_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    copy_r     <= copy_nxt;
    cur_r      <= cur_nxt;
    nx_r       <= nx_nxt;
    p_r        <= p_nxt;
    idx_r      <= idx_nxt;
    ient_r     <= ient_nxt;
    hold_r     <= hold_nxt;
    old_size_r <= old_size_nxt;
  end

  always_comb begin
    out_data.result_addr           = res_r;
    out_data.status                = status_r;
    out_data.copy_bytes            = copy_r;
    out_data.bytes_allocated_total = sum_a_r;
    out_data.bytes_freed_total     = sum_f_r;
    out_data.alloc_count           = n_a_r;
    out_data.free_count            = n_f_r;
  end

  `FFHA_ASSERT_IMP(a_used_range, 1'b1, used_r != '0 && used_r <= CW'(MAX_BLOCKS), "block count out of range")
  `FFHA_ASSERT_IMP(a_split_after_grant, cmd == CMD_SPLIT, $past(cmd) == CMD_GRANT, "split write without grant")
  `FFHA_ASSERT_IMP(a_move_target, cmd == CMD_MOVE_WR, nx_r != '0 && nx_r != last_i, "bad entry move target")

endmodule
